FILE: sv/udpenc_pkg.sv
`timescale 1ns / 1ps

package udpenc_pkg;

  localparam int IP_HEADER_WORDS  = 5;
  localparam int UDP_HEADER_BYTES = 8;
  localparam int ETH_HEADER_BYTES = 14;
  localparam int IP_VERSION       = 4;

  localparam int IP_HDR_BYTES = IP_HEADER_WORDS * 4;
  localparam int HDR_BYTES    = ETH_HEADER_BYTES + IP_HDR_BYTES + UDP_HEADER_BYTES;
  localparam int HDR_BITS     = HDR_BYTES * 8;
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES + 1);
  localparam int HDR_BASE_W   = $clog2(HDR_BITS);

  localparam logic [7:0] VER_IHL = 8'((IP_VERSION << 4) + IP_HEADER_WORDS);

  // Eight static IPv4 header words, then the total length added on top.
  localparam int STATIC_SUM_W = 19;
  localparam int SUM_W        = 20;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DST_MAC   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAC   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_IP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_IP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_PORTS = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IP_ID_FRG = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOS_TTL   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ETHERTYPE = 4'd7;

  localparam logic [23:0] TOS_TTL_RESET   = 24'h404011;
  localparam logic [15:0] ETHERTYPE_RESET = 16'h0800;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [47:0] destination_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] destination_ip;
    logic [31:0] udp_ports;
    logic [31:0] ip_id_and_fragment;
    logic [23:0] ip_tos_ttl_protocol;
    logic [15:0] frame_ethertype;
  } udp_cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_packet;
    logic        last_of_packet;
    logic [15:0] udp_length;
    logic [15:0] ip_total_length;
  } fifo_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: sv/udpenc_if.sv
`timescale 1ns / 1ps

interface udpenc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_of_packet;
  logic        last_of_packet;
  logic [15:0] payload_length;

  modport source (output valid, output payload_byte, output first_of_packet,
                  output last_of_packet, output payload_length, input ready);
  modport sink (input valid, input payload_byte, input first_of_packet,
                input last_of_packet, input payload_length, output ready);
endinterface

interface udpenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_run;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_run,
                  output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_run,
                input end_of_frame, output ready);
endinterface

interface udpenc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/udp_ipv4_ethernet_encapsulator_unit.sv
`timescale 1ns / 1ps

// Inserts a 42-byte Ethernet/IPv4/UDP header in front of each packet of a
// payload byte stream. A payload byte marked first_of_packet brings the
// payload length; the block sends the header, with lengths and the IPv4
// checksum worked out for that packet, and then the byte itself. Other bytes
// pass straight through. The output register sends one frame byte per cycle
// while the receiver is ready. A byte passes through the input register, the
// queue and the output register on its way to the output. The input stage
// and a four-entry queue keep taking payload bytes while the header goes out
// or the output stalls, until the queue is full. Configuration writes are
// always accepted and must only be made while no packet is in flight;
// indexes past seven are ignored.
module udp_ipv4_ethernet_encapsulator_unit import udpenc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  udpenc_in_if.sink     in_ch,
  udpenc_out_if.source  out_ch,
  udpenc_cfg_if.sink    cfg_ch
);

  udp_cfg_t    cfg_r;
  fifo_stat_t  fstat;
  fifo_entry_t push_entry;
  fifo_entry_t head;
  logic        push;
  logic        pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{destination_mac:     '0,
                 source_mac:          '0,
                 source_ip:           '0,
                 destination_ip:      '0,
                 udp_ports:           '0,
                 ip_id_and_fragment:  '0,
                 ip_tos_ttl_protocol: TOS_TTL_RESET,
                 frame_ethertype:     ETHERTYPE_RESET};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DST_MAC:   cfg_r.destination_mac     <= cfg_ch.data;
        REG_SRC_MAC:   cfg_r.source_mac          <= cfg_ch.data;
        REG_SRC_IP:    cfg_r.source_ip           <= cfg_ch.data[31:0];
        REG_DST_IP:    cfg_r.destination_ip      <= cfg_ch.data[31:0];
        REG_UDP_PORTS: cfg_r.udp_ports           <= cfg_ch.data[31:0];
        REG_IP_ID_FRG: cfg_r.ip_id_and_fragment  <= cfg_ch.data[31:0];
        REG_TOS_TTL:   cfg_r.ip_tos_ttl_protocol <= cfg_ch.data[23:0];
        REG_ETHERTYPE: cfg_r.frame_ethertype     <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  udpenc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fstat      (fstat),
    .push       (push),
    .push_entry (push_entry)
  );

  udpenc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .fstat      (fstat)
  );

  udpenc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .fstat  (fstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: sv/udpenc_front.sv
`timescale 1ns / 1ps

module udpenc_front import udpenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  udpenc_in_if.sink   in_ch,
  input  fifo_stat_t  fstat,
  output logic        push,
  output fifo_entry_t push_entry
);

  logic        valid_r;
  fifo_entry_t entry_r;
  logic [15:0] udp_len_nxt;

  assign push        = valid_r && !fstat.full;
  assign in_ch.ready = !valid_r || !fstat.full;
  assign push_entry  = entry_r;

  // Lengths wrap modulo 2^16 like the header fields they feed.
  assign udp_len_nxt = in_ch.payload_length + 16'(UDP_HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      entry_r.payload_byte    <= in_ch.payload_byte;
      entry_r.first_of_packet <= in_ch.first_of_packet;
      entry_r.last_of_packet  <= in_ch.last_of_packet;
      entry_r.udp_length      <= udp_len_nxt;
      entry_r.ip_total_length <= udp_len_nxt + 16'(IP_HDR_BYTES);
    end
  end

endmodule

FILE: sv/udpenc_fifo.sv
`timescale 1ns / 1ps

module udpenc_fifo import udpenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fifo_entry_t push_entry,
  input  logic        pop,
  output fifo_entry_t head,
  output fifo_stat_t  fstat
);

  fifo_entry_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r;
  logic [FIFO_AW-1:0] rptr_r;
  logic [FIFO_AW:0]   count_r;

  assign fstat.full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign fstat.empty = (count_r == '0);
  assign head        = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/udpenc_back.sv
`timescale 1ns / 1ps

module udpenc_back import udpenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  udp_cfg_t    cfg,
  input  fifo_entry_t head,
  input  fifo_stat_t  fstat,
  output logic        pop,
  udpenc_out_if.source out_ch
);

  logic [HDR_IDX_W-1:0]    hdr_idx_r;
  logic [STATIC_SUM_W-1:0] static_sum_r;
  logic [SUM_W-1:0]        sum_r;
  logic [16:0]             fold_r;
  logic [15:0]             cks_r;

  logic       out_valid_r;
  logic [7:0] frame_byte_r;
  logic       end_of_run_r;
  logic       end_of_frame_r;

  logic                  emit;
  logic                  in_hdr;
  logic [HDR_BITS-1:0]   hdr_vec;
  logic [HDR_BASE_W-1:0] hdr_base;
  logic [7:0]            byte_nxt;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_byte   = frame_byte_r;
  assign out_ch.end_of_run   = end_of_run_r;
  assign out_ch.end_of_frame = end_of_frame_r;

  always_comb begin
    emit    = !fstat.empty && (!out_valid_r || out_ch.ready);
    in_hdr  = head.first_of_packet && (hdr_idx_r != HDR_IDX_W'(HDR_BYTES));
    pop     = emit && !in_hdr;
    hdr_vec = {cfg.destination_mac, cfg.source_mac, cfg.frame_ethertype,
               VER_IHL, cfg.ip_tos_ttl_protocol[23:16], head.ip_total_length,
               cfg.ip_id_and_fragment, cfg.ip_tos_ttl_protocol[15:0], cks_r,
               cfg.source_ip, cfg.destination_ip, cfg.udp_ports,
               head.udp_length, 16'h0000};
    hdr_base = HDR_BASE_W'((HDR_BYTES - 1 - int'(hdr_idx_r)) * 8);
    byte_nxt = in_hdr ? hdr_vec[hdr_base +: 8] : head.payload_byte;
  end

  always_ff @(posedge clk) begin
    // Configuration is to change only while idle, which the block does not enforce;
    // then this sum is settled before the next packet needs it.
    static_sum_r <= STATIC_SUM_W'({VER_IHL, cfg.ip_tos_ttl_protocol[23:16]})
                  + STATIC_SUM_W'(cfg.ip_id_and_fragment[31:16])
                  + STATIC_SUM_W'(cfg.ip_id_and_fragment[15:0])
                  + STATIC_SUM_W'(cfg.ip_tos_ttl_protocol[15:0])
                  + STATIC_SUM_W'(cfg.source_ip[31:16])
                  + STATIC_SUM_W'(cfg.source_ip[15:0])
                  + STATIC_SUM_W'(cfg.destination_ip[31:16])
                  + STATIC_SUM_W'(cfg.destination_ip[15:0]);

    if (!rst_n) begin
      hdr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      cks_r       <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        if (in_hdr) begin
          hdr_idx_r <= hdr_idx_r + 1'b1;
        end else begin
          hdr_idx_r <= '0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // The checksum settles over the first three header bytes, well before
      // its own place in the IPv4 header.
      if (emit && in_hdr && hdr_idx_r == HDR_IDX_W'(2)) begin
        cks_r <= ~(16'(fold_r[16]) + fold_r[15:0]);
      end
    end

    if (emit && in_hdr && hdr_idx_r == HDR_IDX_W'(0)) begin
      sum_r <= SUM_W'(static_sum_r) + SUM_W'(head.ip_total_length);
    end
    if (emit && in_hdr && hdr_idx_r == HDR_IDX_W'(1)) begin
      fold_r <= 17'(sum_r[SUM_W-1:16]) + 17'(sum_r[15:0]);
    end
    if (emit) begin
      frame_byte_r   <= byte_nxt;
      end_of_run_r   <= !in_hdr;
      end_of_frame_r <= !in_hdr && head.last_of_packet;
    end
  end

endmodule

FILE: sv/udpenc_checker.sv
`timescale 1ns / 1ps

module udpenc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic       end_of_run,
  input logic       end_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(frame_byte) && $stable(end_of_run)
                                && $stable(end_of_frame))
    else $error("stalled result changed");

  a_eof_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_frame |-> end_of_run)
    else $error("end of frame on a header byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind udp_ipv4_ethernet_encapsulator_unit udpenc_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_byte   (out_ch.frame_byte),
  .end_of_run   (out_ch.end_of_run),
  .end_of_frame (out_ch.end_of_frame)
);

FILE: sim/udp_ipv4_ethernet_encapsulator_unit_test.sv
`timescale 1ns / 1ps

module udp_ipv4_ethernet_encapsulator_unit_test;
  import udpenc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef logic [CFG_DATA_W-1:0] reg_image_t [8];

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_run;
    logic       end_of_frame;
  } frame_beat_t;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
    REG_DST_MAC, REG_SRC_MAC, REG_SRC_IP, REG_DST_IP,
    REG_UDP_PORTS, REG_IP_ID_FRG, REG_TOS_TTL, REG_ETHERTYPE
  };

  class frame_scoreboard;
    logic [47:0] dst_mac = '0;
    logic [47:0] src_mac = '0;
    logic [31:0] src_ip = '0;
    logic [31:0] dst_ip = '0;
    logic [31:0] ports = '0;
    logic [31:0] id_frag = '0;
    logic [23:0] tos_ttl_proto = TOS_TTL_RESET;
    logic [15:0] ethertype = ETHERTYPE_RESET;
    frame_beat_t pending[$];
    int errors;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DST_MAC:   dst_mac = value[47:0];
        REG_SRC_MAC:   src_mac = value[47:0];
        REG_SRC_IP:    src_ip = value[31:0];
        REG_DST_IP:    dst_ip = value[31:0];
        REG_UDP_PORTS: ports = value[31:0];
        REG_IP_ID_FRG: id_frag = value[31:0];
        REG_TOS_TTL:   tos_ttl_proto = value[23:0];
        REG_ETHERTYPE: ethertype = value[15:0];
        default: ;
      endcase
    endfunction

    // Works out the frame bytes that one accepted payload byte must produce.
    function void note_payload_byte(logic [7:0] data, logic first, logic last,
                                    logic [15:0] len);
      logic [15:0] udp_len;
      logic [15:0] ip_len;
      logic [15:0] words [10];
      logic [31:0] sum;
      logic [HDR_BITS-1:0] head;
      if (first) begin
        udp_len = len + 16'(UDP_HEADER_BYTES);
        ip_len = udp_len + 16'(IP_HDR_BYTES);
        words[0] = {4'(IP_VERSION), 4'(IP_HEADER_WORDS), tos_ttl_proto[23:16]};
        words[1] = ip_len;
        words[2] = id_frag[31:16];
        words[3] = id_frag[15:0];
        words[4] = tos_ttl_proto[15:0];
        words[5] = 16'h0000;
        words[6] = src_ip[31:16];
        words[7] = src_ip[15:0];
        words[8] = dst_ip[31:16];
        words[9] = dst_ip[15:0];
        sum = 32'd0;
        foreach (words[i]) sum = sum + words[i];
        while (sum[31:16] != 16'd0) sum = sum[31:16] + sum[15:0];
        words[5] = ~sum[15:0];
        head = {dst_mac, src_mac, ethertype,
                words[0], words[1], words[2], words[3], words[4],
                words[5], words[6], words[7], words[8], words[9],
                ports, udp_len, 16'h0000};
        for (int i = 0; i < HDR_BYTES; i++)
          pending.push_back('{head[HDR_BITS-1-8*i -: 8], 1'b0, 1'b0});
      end
      pending.push_back('{data, 1'b1, last});
    endfunction

    function void check_frame_byte(frame_beat_t seen);
      frame_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: frame byte with nothing expected: expected none, actual %02h/%0b/%0b",
                 $time, seen.frame_byte, seen.end_of_run, seen.end_of_frame);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (seen.frame_byte !== want.frame_byte) begin
        $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                 $time, want.frame_byte, seen.frame_byte);
        errors++;
      end
      if (seen.end_of_run !== want.end_of_run) begin
        $display("%0t: end_of_run mismatch: expected %0b, actual %0b",
                 $time, want.end_of_run, seen.end_of_run);
        errors++;
      end
      if (seen.end_of_frame !== want.end_of_frame) begin
        $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                 $time, want.end_of_frame, seen.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  udpenc_in_if  in_bus ();
  udpenc_out_if out_bus ();
  udpenc_cfg_if cfg_bus ();

  udp_ipv4_ethernet_encapsulator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  frame_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int hold_req_seq = 0;
  int hold_req_len = 0;
  int hold_seen_seq = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver owns its stall counter; a hold-off is requested by bumping
  // the request sequence number.
  always @(posedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left <= hold_req_len;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_beat_t seen;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_payload_byte(in_bus.payload_byte, in_bus.first_of_packet,
                             in_bus.last_of_packet, in_bus.payload_length);
      if (out_bus.valid && out_bus.ready) begin
        seen = '{out_bus.frame_byte, out_bus.end_of_run, out_bus.end_of_frame};
        sb.check_frame_byte(seen);
      end
    end
  end

  task automatic offer_byte(input logic [7:0] data, input logic first, input logic last,
                            input logic [15:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.payload_byte <= data;
    in_bus.first_of_packet <= first;
    in_bus.last_of_packet <= last;
    in_bus.payload_length <= len;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // The length field of the bytes after the first is noise the block must ignore.
  task automatic send_packet(input int count, input logic [15:0] len, input bit with_last);
    for (int i = 0; i < count; i++)
      offer_byte(8'($urandom), i == 0, with_last && (i == count - 1),
                 (i == 0) ? len : 16'($urandom));
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    int size;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      size = $urandom_range(1, 10);
      if (pick < 72)
        send_packet(size, 16'(size), 1'b1);
      else if (pick < 80)
        send_packet(size, 16'($urandom), 1'b1);
      else if (pick < 88)
        offer_byte(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
      else if (pick < 94)
        send_packet(size, 16'(size), 1'b0);
      else
        offer_byte(8'($urandom), 1'b1, 1'($urandom), 16'($urandom));
    end
  endtask

  // Stops offering and waits until every expected frame byte has come out.
  task automatic drain_frames();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input reg_image_t image, input logic [CFG_DATA_W-1:0] stray);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i <= 8; i++) begin
      if (i < 8) begin
        idx = REG_ORDER[i];
        value = image[i];
      end else begin
        // An index past the last register must leave every register alone.
        idx = CFG_IDX_W'($urandom_range(REG_ETHERTYPE + 1, (1 << CFG_IDX_W) - 1));
        value = stray;
      end
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data <= value;
      do @(posedge clk); while (!cfg_bus.ready);
      sb.write_reg(idx, value);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    reg_image_t image;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.payload_byte <= 8'h00;
    in_bus.first_of_packet <= 1'b0;
    in_bus.last_of_packet <= 1'b0;
    in_bus.payload_length <= 16'h0000;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_DST_MAC;
    cfg_bus.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values, a byte with no packet start, a one-byte packet.
    offer_byte(8'h00, 1'b0, 1'b0, 16'hFFFF);
    offer_byte(8'hFF, 1'b1, 1'b1, 16'd1);
    drain_frames();

    foreach (image[i]) image[i] = '1;
    load_config(image, '0);
    // Zero length, lengths that wrap, and the largest legal length.
    offer_byte(8'hA5, 1'b1, 1'b1, 16'd0);
    offer_byte(8'h5A, 1'b1, 1'b0, 16'hFFFF);
    offer_byte(8'h00, 1'b0, 1'b0, 16'h0000);
    offer_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF);
    offer_byte(8'h3C, 1'b1, 1'b1, 16'd65507);
    offer_byte(8'h81, 1'b1, 1'b1, 16'd65509);
    drain_frames();

    foreach (image[i]) image[i] = '0;
    load_config(image, '1);
    offer_byte(8'h11, 1'b1, 1'b0, 16'd3);
    offer_byte(8'h22, 1'b0, 1'b0, 16'hABCD);
    offer_byte(8'h33, 1'b0, 1'b1, 16'h5432);
    offer_byte(8'hC3, 1'b0, 1'b1, 16'h1234);
    // A new packet start before the previous packet was closed.
    offer_byte(8'h44, 1'b1, 1'b0, 16'd2);
    offer_byte(8'h55, 1'b1, 1'b1, 16'd1);

    for (int phase = 0; phase < 3; phase++) begin
      drain_frames();
      foreach (image[i]) image[i] = CFG_DATA_W'({$urandom, $urandom});
      load_config(image, CFG_DATA_W'({$urandom, $urandom}));
      case (phase)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // Long receiver stall while the sender keeps offering, so the
          // queue fills and the input side stalls.
          hold_req_len <= HOLD_OFF_CYCLES;
          hold_req_seq <= hold_req_seq + 1;
        end
      endcase
      random_traffic(50);
      if (phase == 1) drain_frames();
      random_traffic(50);
    end

    drain_frames();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/udpenc_pkg.sv
sv/udpenc_if.sv
sv/udpenc_front.sv
sv/udpenc_fifo.sv
sv/udpenc_back.sv
sv/udp_ipv4_ethernet_encapsulator_unit.sv
sv/udpenc_checker.sv
sim/udp_ipv4_ethernet_encapsulator_unit_test.sv
